// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed");

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk_s, rst_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr)

`endif

`endif

// ===== sv/nrmc_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC checker package
// Character constants, parse phases and the result record of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrmc_pkg;

  // Characters of interest in a sentence.
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_FIX_A  = 8'h41;

  // Parse phases: 0 to 6 walk the header, then the time field and status.
  typedef logic [3:0] phase_t;
  localparam phase_t PH_TIME_FIRST = 4'd7;
  localparam phase_t PH_TIME_REST  = 4'd8;
  localparam phase_t PH_STATUS     = 4'd9;
  localparam phase_t PH_DONE       = 4'd10;

  // Result of one message.
  typedef struct packed {
    logic       fix_lost;
    logic       fix_gained;
    logic       fix_held;
    logic [7:0] status_char;
    logic       rmc_status_present;
    logic       marker_seen;
    logic       checksum_ok;
  } rmc_result_t;

  localparam int RESULT_W = $bits(rmc_result_t);

  // Expected header "$GNRMC," one character at a time.
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h4E;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      3'd6:    ch = 8'h2C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/nrmc_core.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC checker core
// Holds the per-message parse state and the kept fix flag, and works out the
// message result from the byte being consumed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrmc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_message,
  output nrmc_pkg::rmc_result_t result
);
  import nrmc_pkg::*;

  // Per-message state.
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] received_sum, received_sum_next;
  logic       after_marker, after_marker_next;
  logic       hex_done, hex_done_next;
  phase_t     parse_phase, parse_phase_next;
  logic       header_failed, header_failed_next;
  logic [7:0] captured_status, captured_status_next;
  logic       fix_flag, fix_flag_next;

  logic       hex_ok;
  logic [3:0] hex_val;
  logic       sum_ok;
  logic       present;
  logic       fix_new;

  // Hex digit decode, either case.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      hex_val = 4'(data_byte - 8'h30);
    end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
      hex_val = 4'(data_byte - 8'h37);
    end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
      hex_val = 4'(data_byte - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Checksum accumulation and received value.
  always_comb begin
    running_xor_next  = running_xor;
    received_sum_next = received_sum;
    after_marker_next = after_marker;
    hex_done_next     = hex_done;
    if (!after_marker) begin
      if (data_byte == CHAR_DOLLAR) begin
        running_xor_next = '0;
      end else if (data_byte == CHAR_STAR) begin
        after_marker_next = 1'b1;
      end else begin
        running_xor_next = running_xor ^ data_byte;
      end
    end else if (!hex_done) begin
      if (!hex_ok) begin
        hex_done_next = 1'b1;
      end else begin
        received_sum_next = {received_sum[3:0], hex_val};
      end
    end
  end

  // Header, time field and status parsing.
  always_comb begin
    parse_phase_next     = parse_phase;
    header_failed_next   = header_failed;
    captured_status_next = captured_status;
    if (!header_failed && parse_phase < PH_DONE) begin
      if (parse_phase < PH_TIME_FIRST) begin
        if (data_byte == header_char(parse_phase[2:0])) begin
          parse_phase_next = parse_phase + 4'd1;
        end else begin
          header_failed_next = 1'b1;
        end
      end else if (parse_phase == PH_TIME_FIRST) begin
        if (data_byte == CHAR_COMMA) begin
          header_failed_next = 1'b1;
        end else begin
          parse_phase_next = PH_TIME_REST;
        end
      end else if (parse_phase == PH_TIME_REST) begin
        if (data_byte == CHAR_COMMA) begin
          parse_phase_next = PH_STATUS;
        end
      end else begin
        captured_status_next = data_byte;
        parse_phase_next     = PH_DONE;
      end
    end
  end

  // Message verdict and fix tracking.
  always_comb begin
    sum_ok        = after_marker_next && (running_xor_next == received_sum_next);
    present       = !header_failed_next && (parse_phase_next == PH_DONE);
    fix_new       = present && (captured_status_next == CHAR_FIX_A);
    fix_flag_next = sum_ok ? fix_new : fix_flag;

    result.checksum_ok        = sum_ok;
    result.marker_seen        = after_marker_next;
    result.rmc_status_present = present;
    result.status_char        = present ? captured_status_next : 8'h00;
    result.fix_held           = fix_flag_next;
    result.fix_gained         = sum_ok && fix_new && !fix_flag;
    result.fix_lost           = sum_ok && !fix_new && fix_flag;
  end

  // State registers; message state clears after each end of message.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor     <= '0;
      received_sum    <= '0;
      after_marker    <= 1'b0;
      hex_done        <= 1'b0;
      parse_phase     <= '0;
      header_failed   <= 1'b0;
      captured_status <= '0;
      fix_flag        <= 1'b0;
    end else if (take) begin
      if (end_of_message) begin
        running_xor     <= '0;
        received_sum    <= '0;
        after_marker    <= 1'b0;
        hex_done        <= 1'b0;
        parse_phase     <= '0;
        header_failed   <= 1'b0;
        captured_status <= '0;
        fix_flag        <= fix_flag_next;
      end else begin
        running_xor     <= running_xor_next;
        received_sum    <= received_sum_next;
        after_marker    <= after_marker_next;
        hex_done        <= hex_done_next;
        parse_phase     <= parse_phase_next;
        header_failed   <= header_failed_next;
        captured_status <= captured_status_next;
      end
    end
  end

endmodule

// ===== sv/nmea_rmc_checksum_fix_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC checksum and fix tracker
// The unit takes one message byte per transaction and gives one result
// transaction per message, on the byte marked by tlast. It accepts one byte
// every clock cycle: a byte is held in an input register, the checksum and
// header logic work on it there, and the message result lands in an output
// register when its last byte leaves the input register. Only a stalled
// output register holding back a second result stops the input; the
// per-byte state update is a single XOR, compare and phase step, which sets
// the rate at one byte per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nmea_rmc_checksum_fix_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] checksum_ok, [1] marker_seen, [2] rmc_status_present,
  // [10:3] status_char, [11] fix_held, [12] fix_gained, [13] fix_lost,
  // [15:14] zero
  output logic [15:0] m_axis_tdata
);
  import nrmc_pkg::*;

  // Input register.
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_free;
  logic        take;
  rmc_result_t core_result;
  rmc_result_t out_result;

  // A byte leaves the input register unless it closes a message and the
  // output register cannot take the result.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign take          = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Parse and checksum logic.
  nrmc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (in_byte),
    .end_of_message (in_last),
    .result         (core_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tdata = {{(16 - RESULT_W){1'b0}}, out_result};

  // Checks on the result logic.
  `ASSERT_NEVER(a_pulses_exclusive, clk, rst,
    m_axis_tvalid && out_result.fix_gained && out_result.fix_lost)
  `ASSERT_PROP(a_gain_sets_fix, clk, rst,
    (m_axis_tvalid && out_result.fix_gained) |-> out_result.fix_held)
  `ASSERT_PROP(a_loss_clears_fix, clk, rst,
    (m_axis_tvalid && out_result.fix_lost) |-> !out_result.fix_held)
  `ASSERT_PROP(a_ok_needs_marker, clk, rst,
    (m_axis_tvalid && out_result.checksum_ok) |-> out_result.marker_seen)
  `ASSERT_PROP(a_result_follows_last, clk, rst,
    $rose(m_axis_tvalid) |-> $past(take && in_last))

endmodule
